### rtl/core/slice_index_normalizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slice index normalizer.
// Checks compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SLICE_INDEX_NORMALIZER_ASSERT_SVH
`define SLICE_INDEX_NORMALIZER_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SIN_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("slice index normalizer check failed");
// Condition must never be seen at a clock edge outside reset.
`define SIN_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("slice index normalizer forbidden condition");
`else
`define SIN_ASSERT(label, clk, rst_n, prop)
`define SIN_NEVER(label, clk, rst_n, expr)
`endif

`endif

### rtl/core/sin_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sin_pkg
// Shared types and constants of the slice index normalizer.
// ----------------------------------------------------------------------------
package sin_pkg;

    localparam int DIV_W          = 32;
    localparam int DIV_BITS_STAGE = 4;
    localparam int DIV_STAGES     = DIV_W / DIV_BITS_STAGE;

    localparam logic signed [63:0] BEGIN_MARK = {1'b1, 63'b0};
    localparam logic signed [63:0] END_MARK   = {1'b0, {63{1'b1}}};

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_SINGLE = 2'd1,
        ERR_RANGE  = 2'd2
    } t_err;

    // Result fields that ride alongside the divider.
    typedef struct packed {
        logic              drop;
        logic [31:0]       first;
        logic [63:0]       stride;
        logic [31:0]       len;
        t_err              err;
        logic              use_div;
    } t_meta;

endpackage

### rtl/core/sin_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sin_in_if / sin_out_if
// Valid/ready channels carrying axis descriptors and normalized results.
// ----------------------------------------------------------------------------
interface sin_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        axis_size;
    logic signed [63:0] slice_start;
    logic signed [63:0] slice_finish;
    logic signed [63:0] slice_step;
    logic               unindexed;

    modport source (output valid, axis_size, slice_start, slice_finish, slice_step,
                    unindexed, input ready);
    modport sink   (input valid, axis_size, slice_start, slice_finish, slice_step,
                    unindexed, output ready);
endinterface

interface sin_out_if;
    logic               valid;
    logic               ready;
    logic               drop_axis;
    logic [31:0]        first_index;
    logic signed [63:0] index_stride;
    logic [31:0]        out_length;
    logic [1:0]         error_code;

    modport source (output valid, drop_axis, first_index, index_stride, out_length,
                    error_code, input ready);
    modport sink   (input valid, drop_axis, first_index, index_stride, out_length,
                    error_code, output ready);
endinterface

### rtl/core/sin_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sin_div
// Pipelined restoring divider, a few quotient bits per stage, with side data.
// ----------------------------------------------------------------------------
module sin_div
    import sin_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_meta            i_meta,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_valid,
    output t_meta            o_meta,
    output logic [DIV_W-1:0] o_quot
);

    logic             r_valid [DIV_STAGES];
    t_meta            r_meta  [DIV_STAGES];
    logic [DIV_W-1:0] r_rem   [DIV_STAGES];
    logic [DIV_W-1:0] r_quot  [DIV_STAGES];
    logic [DIV_W-1:0] r_dsr   [DIV_STAGES];

    // Runs a handful of restoring steps; quotient bits shift in at the bottom
    // while dividend bits shift out at the top.
    function automatic logic [2*DIV_W-1:0] div_steps(
        input logic [DIV_W-1:0] rem_in,
        input logic [DIV_W-1:0] quot_in,
        input logic [DIV_W-1:0] dsr
    );
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] quot;
        logic [DIV_W:0]   trial;
        rem  = rem_in;
        quot = quot_in;
        for (int k = 0; k < DIV_BITS_STAGE; k++) begin
            trial = {rem, quot[DIV_W-1]};
            if (trial >= {1'b0, dsr}) begin
                trial = trial - {1'b0, dsr};
                quot  = {quot[DIV_W-2:0], 1'b1};
            end else begin
                quot  = {quot[DIV_W-2:0], 1'b0};
            end
            rem = trial[DIV_W-1:0];
        end
        return {rem, quot};
    endfunction

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic             w_valid;
        t_meta            w_meta;
        logic [DIV_W-1:0] w_rem;
        logic [DIV_W-1:0] w_quot;
        logic [DIV_W-1:0] w_dsr;
        logic [2*DIV_W-1:0] w_res;

        if (g == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_meta  = i_meta;
            assign w_rem   = '0;
            assign w_quot  = i_dividend;
            assign w_dsr   = i_divisor;
        end else begin : g_next
            assign w_valid = r_valid[g-1];
            assign w_meta  = r_meta[g-1];
            assign w_rem   = r_rem[g-1];
            assign w_quot  = r_quot[g-1];
            assign w_dsr   = r_dsr[g-1];
        end

        assign w_res = div_steps(w_rem, w_quot, w_dsr);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_meta[g] <= w_meta;
                r_rem[g]  <= w_res[2*DIV_W-1:DIV_W];
                r_quot[g] <= w_res[DIV_W-1:0];
                r_dsr[g]  <= w_dsr;
            end
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_meta  = r_meta[DIV_STAGES-1];
    assign o_quot  = r_quot[DIV_STAGES-1];

endmodule

### rtl/core/slice_index_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slice_index_normalizer
// Turns a Python-style axis index into first index, stride, length and flags.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word
//  i_item    in         axis_size, slice_start, slice_finish, slice_step,
//                       unindexed
//  o_res     out        drop_axis, first_index, index_stride, out_length,
//                       error_code
//
// One word enters per cycle unless the output stalls; each result passes
// one decode stage, eight divider stages of four quotient bits and one
// output register. The length divider sets the latency. Reset clears only
// the valid bits. A stall at the output freezes every stage at once.
// ----------------------------------------------------------------------------
`include "slice_index_normalizer_assert.svh"

module slice_index_normalizer
    import sin_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sin_in_if.sink      i_item,
    sin_out_if.source   o_res
);

    logic               w_en;
    logic               r_dec_valid;
    t_meta              r_dec_meta;
    logic [DIV_W-1:0]   r_dividend;
    logic [DIV_W-1:0]   r_divisor;
    t_meta              n_meta;
    logic [DIV_W-1:0]   n_dividend;
    logic [DIV_W-1:0]   n_divisor;
    logic               w_div_valid;
    t_meta              w_div_meta;
    logic [DIV_W-1:0]   w_quot;
    logic               r_out_valid;
    t_meta              r_out;
    t_meta              n_out;

    logic signed [63:0] w_s;
    logic signed [63:0] w_st;
    logic signed [63:0] w_fi;
    logic signed [63:0] w_stp;
    logic signed [63:0] w_sn;
    logic signed [63:0] w_fn;
    logic signed [63:0] w_span;
    logic signed [63:0] w_spm1;
    logic [63:0]        w_mag;
    logic               w_pos;
    logic               w_bad;

    assign w_en         = !r_out_valid || o_res.ready;
    assign i_item.ready = w_en;

    assign w_s   = $signed({32'b0, i_item.axis_size});
    assign w_st  = i_item.slice_start;
    assign w_fi  = i_item.slice_finish;
    assign w_stp = i_item.slice_step;
    assign w_pos = !w_stp[63] && (w_stp != 64'sd0);

    // Decode: unindexed and single-index cases, plus bounds checks, wrapping and span for the range case.
    always_comb begin
        n_meta     = '{drop: 1'b0, first: '0, stride: '0, len: '0,
                       err: ERR_NONE, use_div: 1'b0};
        n_dividend = '0;
        n_divisor  = '1;
        w_sn       = w_st;
        w_fn       = w_fi;
        w_bad      = 1'b0;
        w_span     = '0;
        w_spm1     = '0;
        w_mag      = w_pos ? w_stp : 64'(-w_stp);

        if (i_item.unindexed) begin
            n_meta.stride = 64'd1;
            n_meta.len    = i_item.axis_size;
        end else if (w_stp == 64'sd0) begin
            if (!w_st[63] && w_st < w_s) begin
                n_meta.drop  = 1'b1;
                n_meta.first = w_st[31:0];
                n_meta.len   = 32'd1;
            end else if (w_st[63] && w_st >= -w_s) begin
                n_meta.drop  = 1'b1;
                n_meta.first = w_sn[31:0] + i_item.axis_size;
                n_meta.len   = 32'd1;
            end else begin
                n_meta.err = ERR_SINGLE;
            end
        end else begin
            if (!w_st[63]) begin
                w_bad = w_bad || (w_st >= w_s);
            end else if (w_st >= -w_s) begin
                w_sn = w_st + w_s;
            end else if (w_st == BEGIN_MARK) begin
                w_sn = w_pos ? 64'sd0 : w_s - 64'sd1;
            end else begin
                w_bad = 1'b1;
            end

            if (!w_fi[63]) begin
                if (w_pos ? (w_fi > w_s) : (w_fi >= w_s)) begin
                    if (w_fi == END_MARK) begin
                        w_fn = w_pos ? w_s : -64'sd1;
                    end else begin
                        w_bad = 1'b1;
                    end
                end
            end else if (w_fi >= -w_s) begin
                w_fn = w_fi + w_s;
            end else begin
                w_bad = 1'b1;
            end

            w_span = w_pos ? (w_fn - w_sn) : (w_sn - w_fn);
            w_spm1 = w_span - 64'sd1;

            if (w_bad) begin
                n_meta.err = ERR_RANGE;
            end else if (w_span <= 64'sd0) begin
                n_meta.stride = 64'd1;
            end else begin
                n_meta.first   = w_sn[31:0];
                n_meta.stride  = w_stp;
                n_meta.use_div = 1'b1;
                n_dividend     = w_spm1[31:0];
                // The span stays below 2^32, so a wider step gives quotient 0.
                n_divisor      = (w_mag[63:32] != 32'd0) ? '1 : w_mag[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_valid <= 1'b0;
        end else if (w_en) begin
            r_dec_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dec_meta <= n_meta;
            r_dividend <= n_dividend;
            r_divisor  <= n_divisor;
        end
    end

    sin_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_dec_valid),
        .i_meta     (r_dec_meta),
        .i_dividend (r_dividend),
        .i_divisor  (r_divisor),
        .o_valid    (w_div_valid),
        .o_meta     (w_div_meta),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div_valid;
        end
    end

    always_comb begin
        n_out = w_div_meta;
        if (w_div_meta.use_div) begin
            n_out.len = w_quot + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.drop_axis    = r_out.drop;
    assign o_res.first_index  = r_out.first;
    assign o_res.index_stride = r_out.stride;
    assign o_res.out_length   = r_out.len;
    assign o_res.error_code   = r_out.err;

    `SIN_ASSERT(a_err_zero, i_clk, i_rst_n, (o_res.valid && o_res.error_code != ERR_NONE) |-> (o_res.out_length == 32'd0 && o_res.index_stride == 64'sd0 && !o_res.drop_axis))
    `SIN_ASSERT(a_drop_len, i_clk, i_rst_n, (o_res.valid && o_res.drop_axis) |-> (o_res.out_length == 32'd1 && o_res.index_stride == 64'sd0))
    `SIN_NEVER(a_stall_ready, i_clk, i_rst_n, o_res.valid && !o_res.ready && i_item.ready)

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives axis descriptors into the slice index normalizer and checks every
// normalized result in order against a behavioral predictor. Covers
// unindexed axes, single indices, forward and backward ranges, sentinels,
// wrapping, empty slices and out-of-range errors, under random idling and
// one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    import sin_pkg::*;

    typedef struct packed {
        logic        drop;
        logic [31:0] first;
        logic [63:0] stride;
        logic [31:0] len;
        t_err        err;
    } t_norm;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    sin_in_if  item_ch ();
    sin_out_if res_ch ();

    slice_index_normalizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch.sink),
        .o_res   (res_ch.source)
    );

    always #2 i_clk = ~i_clk;

    t_norm expected_q[$];
    int    mismatches = 0;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    bit    hold_off = 1'b0;

    initial begin
        item_ch.valid        = 1'b0;
        item_ch.axis_size    = '0;
        item_ch.slice_start  = '0;
        item_ch.slice_finish = '0;
        item_ch.slice_step   = '0;
        item_ch.unindexed    = 1'b0;
        res_ch.ready         = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("MISMATCH %s: got %h expected %h", what, got, want);
    endtask

    function automatic t_norm normalize(input logic [31:0] size,
                                        input logic signed [63:0] start_in,
                                        input logic signed [63:0] finish_in,
                                        input logic signed [63:0] step,
                                        input logic unindexed);
        t_norm r;
        logic signed [65:0] s, st, fi, span;
        logic [63:0] mag;
        r = '{drop: 1'b0, first: '0, stride: '0, len: '0, err: ERR_NONE};
        s  = {34'd0, size};
        st = start_in;
        fi = finish_in;
        if (unindexed) begin
            r.stride = 64'd1;
            r.len = size;
            return r;
        end
        if (step == 0) begin
            if (st >= 0 && st < s) begin
                r.drop = 1'b1; r.first = st[31:0]; r.len = 32'd1;
            end else if (st < 0 && st >= -s) begin
                r.drop = 1'b1; r.first = 32'(st + s); r.len = 32'd1;
            end else begin
                r.err = ERR_SINGLE;
            end
            return r;
        end
        r.err = ERR_RANGE;
        if (st >= 0) begin
            if (st >= s) return r;
        end else if (st >= -s) begin
            st = st + s;
        end else if (start_in == BEGIN_MARK) begin
            st = (step > 0) ? 66'sd0 : s - 1;
        end else begin
            return r;
        end
        if (fi >= 0) begin
            if ((step > 0) ? (fi > s) : (fi >= s)) begin
                if (finish_in == END_MARK) fi = (step > 0) ? s : -66'sd1;
                else return r;
            end
        end else if (fi >= -s) begin
            fi = fi + s;
        end else begin
            return r;
        end
        r.err = ERR_NONE;
        if (step > 0) begin
            span = fi - st;
            mag = step;
        end else begin
            span = st - fi;
            mag = 64'd0 - step;
        end
        if (span <= 0) begin
            r.stride = 64'd1;
            return r;
        end
        r.first = st[31:0];
        r.stride = step;
        r.len = 32'((64'(span) - 64'd1) / mag + 64'd1);
        return r;
    endfunction

    // Valid stays high from one word to the next unless the sender idles.
    task automatic send_descriptor(input logic [31:0] size, input logic [63:0] start_v,
                                   input logic [63:0] finish_v, input logic [63:0] step_v,
                                   input logic unindexed);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.axis_size    <= size;
        item_ch.slice_start  <= start_v;
        item_ch.slice_finish <= finish_v;
        item_ch.slice_step   <= step_v;
        item_ch.unindexed    <= unindexed;
        expected_q.push_back(normalize(size, start_v, finish_v, step_v, unindexed));
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    // Sink side: random ready, forced low during a hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_norm want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word", 64'd0, 64'd0);
            end else begin
                want = expected_q.pop_front();
                if (res_ch.drop_axis !== want.drop)
                    report_mismatch("drop_axis", res_ch.drop_axis, want.drop);
                if (res_ch.first_index !== want.first)
                    report_mismatch("first_index", res_ch.first_index, want.first);
                if (res_ch.index_stride !== want.stride)
                    report_mismatch("index_stride", res_ch.index_stride, want.stride);
                if (res_ch.out_length !== want.len)
                    report_mismatch("out_length", res_ch.out_length, want.len);
                if (res_ch.error_code !== want.err)
                    report_mismatch("error_code", res_ch.error_code, want.err);
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Picks an index near the interesting boundaries of an axis of this size.
    function automatic logic [63:0] pick_index(input logic [31:0] size);
        logic signed [63:0] s;
        s = {32'd0, size};
        case ($urandom_range(9))
            0: return BEGIN_MARK;
            1: return END_MARK;
            2: return rand64();
            3: return s;
            4: return -s;
            5: return -s - 1;
            6: return s - 1;
            default: begin
                if (size == 0) return 64'd0;
                return ($urandom_range(1)) ? 64'($urandom_range(size - 1))
                                           : -64'($urandom_range(size - 1) + 1);
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(20);
        endcase
    endfunction

    function automatic logic [63:0] pick_step();
        case ($urandom_range(9))
            0: return 64'd0;
            1: return BEGIN_MARK;
            2: return END_MARK;
            3: return rand64();
            4, 5: return 64'($urandom_range(5) + 1);
            default: return -64'($urandom_range(5) + 1);
        endcase
    endfunction

    task automatic test_directed();
        send_descriptor(32'd7, 64'd3, 64'd0, 64'd0, 1'b1);
        send_descriptor(32'hFFFF_FFFF, rand64(), rand64(), rand64(), 1'b1);
        send_descriptor(32'd0, 64'd0, 64'd0, 64'd0, 1'b1);
        send_descriptor(32'd5, 64'd4, 64'd0, 64'd0, 1'b0);
        send_descriptor(32'd5, -64'd5, 64'd0, 64'd0, 1'b0);
        send_descriptor(32'd5, 64'd5, 64'd0, 64'd0, 1'b0);
        send_descriptor(32'd5, -64'd6, 64'd0, 64'd0, 1'b0);
        send_descriptor(32'd0, 64'd0, 64'd0, 64'd0, 1'b0);
        send_descriptor(32'd10, BEGIN_MARK, END_MARK, 64'd1, 1'b0);
        send_descriptor(32'd10, BEGIN_MARK, END_MARK, -64'd1, 1'b0);
        send_descriptor(32'd10, BEGIN_MARK, END_MARK, 64'd3, 1'b0);
        send_descriptor(32'd10, -64'd1, -64'd10, -64'd4, 1'b0);
        send_descriptor(32'd10, 64'd2, 64'd10, 64'd2, 1'b0);
        send_descriptor(32'd10, 64'd2, 64'd11, 64'd2, 1'b0);
        send_descriptor(32'd10, 64'd9, 64'd10, -64'd1, 1'b0);
        send_descriptor(32'd10, 64'd10, END_MARK, 64'd1, 1'b0);
        send_descriptor(32'd10, -64'd11, END_MARK, 64'd1, 1'b0);
        send_descriptor(32'd10, 64'd6, 64'd2, 64'd1, 1'b0);
        send_descriptor(32'd10, 64'd2, 64'd6, -64'd1, 1'b0);
        send_descriptor(32'd10, 64'd0, END_MARK, END_MARK, 1'b0);
        send_descriptor(32'd10, BEGIN_MARK, END_MARK, BEGIN_MARK, 1'b0);
        send_descriptor(32'hFFFF_FFFF, BEGIN_MARK, END_MARK, 64'd1, 1'b0);
        send_descriptor(32'hFFFF_FFFF, BEGIN_MARK, END_MARK, -64'd1, 1'b0);
        send_descriptor(32'd0, BEGIN_MARK, END_MARK, 64'd1, 1'b0);
    endtask

    task automatic test_random(input int count);
        logic [31:0] size;
        repeat (count) begin
            size = pick_size();
            if ($urandom_range(19) == 0)
                send_descriptor(size, rand64(), rand64(), rand64(), $urandom_range(1));
            else
                send_descriptor(size, pick_index(size), pick_index(size), pick_step(),
                                $urandom_range(15) == 0);
        end
    endtask

    // The sink stops for a long stretch while the source keeps offering.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(posedge i_clk);
                hold_off = 1'b0;
            end
            test_random(40);
        join
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 9;
        recv_idle_pct = 65;
        test_directed();
        test_random(330);
        send_idle_pct = 65;
        recv_idle_pct = 9;
        test_random(330);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(330);
        drain();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule
